// File: src/mhws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhws_pkg
// Shared widths, register indexes and pipeline control type for the
// hourglass window sum unit.
// ----------------------------------------------------------------------------
package mhws_pkg;

   localparam int PIX_W  = 8;
   localparam int SUM_W  = 11;
   localparam int ROW_W  = 12;
   localparam int GCOL_W = 11;
   localparam int OCOL_W = 10;
   localparam int CSR_W  = 12;
   localparam int IDX_W  = 1;

   typedef enum logic [IDX_W-1:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic win_ok;
   } stage_ctrl_type;

endpackage

// File: src/mhws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhws_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mhws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mhws_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhws_window
// 3x3 window shift register, hourglass adder tree and running maximum with
// its top-left position.
// ----------------------------------------------------------------------------
module mhws_window #(
   parameter int COL_W = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  mhws_pkg::stage_ctrl_type      ctrl,
   input  logic [mhws_pkg::PIX_W-1:0]    pixel,
   input  logic [mhws_pkg::PIX_W-1:0]    upper,
   input  logic [mhws_pkg::PIX_W-1:0]    lower,
   input  logic [mhws_pkg::ROW_W-1:0]    row,
   input  logic [COL_W-1:0]              col,
   output logic [mhws_pkg::SUM_W-1:0]    best_sum,
   output logic [mhws_pkg::ROW_W-1:0]    best_row,
   output logic [COL_W-1:0]              best_col
);

   import mhws_pkg::*;

   logic [PIX_W-1:0] cells_ff [9];
   logic [PIX_W-1:0] cells_in [9];
   logic [SUM_W-1:0] max_ff,  max_in;
   logic [ROW_W-1:0] mrow_ff, mrow_in;
   logic [COL_W-1:0] mcol_ff, mcol_in;
   logic [SUM_W-1:0] sum;
   logic             upd;

   always_comb begin
      cells_in[0] = cells_ff[1];
      cells_in[1] = cells_ff[2];
      cells_in[2] = upper;
      cells_in[3] = cells_ff[4];
      cells_in[4] = cells_ff[5];
      cells_in[5] = lower;
      cells_in[6] = cells_ff[7];
      cells_in[7] = cells_ff[8];
      cells_in[8] = pixel;
   end

   // hourglass: top row, centre, bottom row
   assign sum = SUM_W'(cells_in[0]) + SUM_W'(cells_in[1]) + SUM_W'(cells_in[2])
              + SUM_W'(cells_in[4])
              + SUM_W'(cells_in[6]) + SUM_W'(cells_in[7]) + SUM_W'(cells_in[8]);

   assign upd     = ctrl.valid && ctrl.win_ok && (sum >= max_ff);
   assign max_in  = upd ? sum : max_ff;
   assign mrow_in = upd ? ROW_W'(row - ROW_W'(2)) : mrow_ff;
   assign mcol_in = upd ? COL_W'(col - COL_W'(2)) : mcol_ff;

   assign best_sum = max_in;
   assign best_row = mrow_in;
   assign best_col = mcol_in;

   always_ff @(posedge clock) begin
      if (reset || restart || (ctrl.valid && ctrl.last)) begin
         for (int i = 0; i < 9; i++) begin
            cells_ff[i] <= '0;
         end
         max_ff  <= '0;
         mrow_ff <= '0;
         mcol_ff <= '0;
      end else if (ctrl.valid) begin
         for (int i = 0; i < 9; i++) begin
            cells_ff[i] <= cells_in[i];
         end
         max_ff  <= max_in;
         mrow_ff <= mrow_in;
         mcol_ff <= mcol_in;
      end
   end

endmodule

// File: src/max_hourglass_window_sum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_hourglass_window_sum_unit
// Largest 3x3 hourglass sum over a raster-scanned grid, with its position.
// ----------------------------------------------------------------------------
// usage:
//   pixels arrive on the req_ channel in raster order, one transaction per
//   pixel. grid size is set through csr_ (index 0 rows, index 1 columns)
//   while the unit is idle; a write restarts the current grid.
//   one rsp_ transaction follows the last pixel of each grid, carrying the
//   largest hourglass sum and the top-left row and column of its window.
//   throughput is one pixel per cycle, but a grid's last pixel is held while
//   the previous result loads. the two line store RAMs are read at
//   acceptance and written back in the following cycle, with forwarding
//   on a same-column hit. the result goes through the stage-1 and output registers.
//   while a result waits on rsp_ready, pixels are still taken, except that
//   the last pixel of the next grid is held until the output slot frees.
//   reset clears counters, window, maximum and the output valid flag; the
//   line stores need no clearing, so the unit is ready the cycle after.
// ----------------------------------------------------------------------------
module max_hourglass_window_sum_unit #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mhws_pkg::PIX_W-1:0]    req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mhws_pkg::SUM_W-1:0]    rsp_best_sum,
   output logic [mhws_pkg::ROW_W-1:0]    rsp_best_row,
   output logic [mhws_pkg::OCOL_W-1:0]   rsp_best_col,
   input  logic                          csr_write_enable,
   input  logic [mhws_pkg::IDX_W-1:0]    csr_index,
   input  logic [mhws_pkg::CSR_W-1:0]    csr_write_data
);

   import mhws_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int CMP_W = (COL_W + 1 > GCOL_W) ? COL_W + 1 : GCOL_W;
   localparam logic [PIX_W-1:0] PIX_MASK =
      (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

   logic [ROW_W-1:0]  grid_rows_ff, grid_rows_in;
   logic [GCOL_W-1:0] grid_cols_ff, grid_cols_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   stage_ctrl_type    s1_ctrl_ff, s1_ctrl_in;
   logic [PIX_W-1:0]  s1_px_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              fwd_ff;
   logic [PIX_W-1:0]  fwd_upper_ff, fwd_lower_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  out_sum_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W-1:0]  out_col_ff;

   logic [ROW_W-1:0]  eff_rows;
   logic [CMP_W-1:0]  cols_ext, eff_cols;
   logic              col_end, row_end, cur_last, accept, result_load;
   logic [PIX_W-1:0]  upper_rd, lower_rd, upper_eff, lower_eff;
   logic [SUM_W-1:0]  win_sum;
   logic [ROW_W-1:0]  win_row;
   logic [COL_W-1:0]  win_col;
   logic [COL_W+OCOL_W-1:0] col_wide;

   // effective grid size
   assign eff_rows = (grid_rows_ff == '0) ? ROW_W'(1) : grid_rows_ff;
   assign cols_ext = CMP_W'(grid_cols_ff);
   always_comb begin
      if (cols_ext == '0) begin
         eff_cols = CMP_W'(1);
      end else if (cols_ext > CMP_W'(MAX_COLS)) begin
         eff_cols = CMP_W'(MAX_COLS);
      end else begin
         eff_cols = cols_ext;
      end
   end

   assign col_end  = (CMP_W'(col_ff) + CMP_W'(1)) >= eff_cols;
   assign row_end  = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, eff_rows};
   assign cur_last = col_end && row_end;

   assign result_load = s1_ctrl_ff.valid && s1_ctrl_ff.last;
   assign req_ready   = !cur_last ||
                        (!result_load && !(rsp_valid_ff && !rsp_ready));
   assign accept      = req_valid && req_ready;

   // configuration and raster counters
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_ROWS: grid_rows_in = csr_write_data[ROW_W-1:0];
            CSR_GRID_COLS: grid_cols_in = csr_write_data[GCOL_W-1:0];
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : ROW_W'(row_ff + ROW_W'(1));
         end else begin
            col_in = COL_W'(col_ff + COL_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= ROW_W'(3);
         grid_cols_ff <= GCOL_W'(3);
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // line stores
   mhws_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_upper (
      .clock   (clock),
      .wr_en   (s1_ctrl_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (lower_eff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   mhws_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_lower (
      .clock   (clock),
      .wr_en   (s1_ctrl_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lower_rd)
   );

   // same-column write in flight at read time
   assign upper_eff = fwd_ff ? fwd_upper_ff : upper_rd;
   assign lower_eff = fwd_ff ? fwd_lower_ff : lower_rd;

   always_comb begin
      s1_ctrl_in.valid  = accept;
      s1_ctrl_in.last   = cur_last;
      s1_ctrl_in.win_ok = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= req_pixel & PIX_MASK;
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         fwd_ff       <= s1_ctrl_ff.valid && (s1_col_ff == col_ff);
         fwd_upper_ff <= lower_eff;
         fwd_lower_ff <= s1_px_ff;
      end
   end

   mhws_window #(.COL_W(COL_W)) u_window (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_write_enable),
      .ctrl     (s1_ctrl_ff),
      .pixel    (s1_px_ff),
      .upper    (upper_eff),
      .lower    (lower_eff),
      .row      (s1_row_ff),
      .col      (s1_col_ff),
      .best_sum (win_sum),
      .best_row (win_row),
      .best_col (win_col)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         out_sum_ff <= win_sum;
         out_row_ff <= win_row;
         out_col_ff <= win_col;
      end
   end

   assign col_wide     = {{OCOL_W{1'b0}}, out_col_ff};
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = out_sum_ff;
   assign rsp_best_row = out_row_ff;
   assign rsp_best_col = col_wide[OCOL_W-1:0];

endmodule

// File: src/mhws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhws_checker
// Port-level checks for the hourglass window sum unit, bound to the top level.
// ----------------------------------------------------------------------------
module mhws_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [mhws_pkg::PIX_W-1:0]    req_pixel,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mhws_pkg::SUM_W-1:0]    rsp_best_sum,
   input logic [mhws_pkg::ROW_W-1:0]    rsp_best_row,
   input logic [mhws_pkg::OCOL_W-1:0]   rsp_best_col
);

   import mhws_pkg::*;

   // stalled pixel transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_pixel))
      else $error("pixel changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_sum) &&
      $stable(rsp_best_row) && $stable(rsp_best_col))
      else $error("result changed while stalled");

   // nothing pending straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // seven cells of at most 255
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_sum <= SUM_W'(1785))
      else $error("sum out of range");

   // top row of a window lies at least two rows above the last row
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_row <= ROW_W'(4092))
      else $error("row out of range");

endmodule

bind max_hourglass_window_sum_unit mhws_checker u_mhws_checker (.*);
